### rtl/cdda_pkg.sv
package cdda_pkg;

  // input word kinds
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_SUB  = 2'd1;
  localparam logic [1:0] KIND_LOAD = 2'd2;

  // calendar limits and reset date
  localparam logic [13:0] YEAR_MIN   = 14'd1;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [13:0] YEAR_RESET = 14'd1900;
  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;
  localparam logic [4:0]  DAY_FIRST  = 5'd1;
  localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;

  // year split into year mod 100 and century mod 4 for the leap rule
  localparam logic [6:0] LO_MAX    = 7'd99;
  localparam logic [6:0] LO_RESET  = 7'd0;
  localparam logic [1:0] HI2_RESET = 2'd3;

  // year / 100 as a reciprocal multiply, exact for 14-bit years
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  // datapath operations selected by the control word
  typedef enum logic [1:0] {
    OP_ACCEPT,
    OP_SPLIT,
    OP_WALK,
    OP_COMMIT
  } op_t;

  // jump conditions
  typedef enum logic [1:0] {
    JC_NO_ACCEPT,
    JC_SKIP,
    JC_WALKING,
    JC_OUT_BUSY
  } jc_t;

  typedef logic [1:0] pc_t;

  typedef struct packed {
    op_t op;
    jc_t jc;
    pc_t target;
  } ctl_t;

  typedef struct packed {
    logic accept;
    logic skip;
    logic walking;
    logic out_busy;
  } flags_t;

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    len = 5'd31;
    case (m)
      4'd2:    len = leap ? FEB_LEAP_LEN : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic is_leap(logic [6:0] lo, logic [1:0] hi2);
    return ((lo[1:0] == 2'd0) && (lo != 7'd0)) || ((lo == 7'd0) && (hi2 == 2'd0));
  endfunction

endpackage

### rtl/cdda_if.sv
interface cdda_in_if #(parameter int COUNT_BITS = 16) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [COUNT_BITS-1:0] day_count;
  logic [4:0]            load_day;
  logic [3:0]            load_month;
  logic [13:0]           load_year;

  modport source (output valid, kind, day_count, load_day, load_month, load_year,
                  input ready);
  modport sink   (input valid, kind, day_count, load_day, load_month, load_year,
                  output ready);
endinterface

interface cdda_out_if ();
  logic        valid;
  logic        ready;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic        leap_year;
  logic        out_of_range;

  modport source (output valid, day, month, year, leap_year, out_of_range, input ready);
  modport sink   (input valid, day, month, year, leap_year, out_of_range, output ready);
endinterface

### rtl/calendar_date_day_adder_top.sv
// a word that changes the date passes the accept, split, month walk and commit steps;
// the month walk does one month a cycle, and the commit waits while the last result is not taken
// a new word is taken only back in idle after the commit; a 16-bit count crosses up to about 2200 months
// unused kinds and refused load years skip the month walk and go from split straight to commit
// reset (synchronous, active low) sets the date to 1/1/1900 and empties the result register
module calendar_date_day_adder_top #(
  parameter int COUNT_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  cdda_in_if.sink    in_ch,
  cdda_out_if.source out_ch
);

  localparam int WD_W = COUNT_BITS + 2;

  cdda_pkg::ctl_t   ctl;
  cdda_pkg::flags_t flags;

  // committed date
  logic [4:0]  cur_day_r;
  logic [3:0]  cur_month_r;
  logic [13:0] cur_year_r;
  logic [6:0]  cur_lo_r;
  logic [1:0]  cur_hi2_r;

  // working date
  logic signed [WD_W-1:0] wd_r;
  logic [3:0]             wm_r;
  logic [13:0]            wy_r;
  logic [6:0]             w_lo_r;
  logic [1:0]             w_hi2_r;
  logic [7:0]             q_r;
  logic                   load_r, err_r, keep_r;

  // result register
  logic        out_valid_r;
  logic [4:0]  out_day_r;
  logic [3:0]  out_month_r;
  logic [13:0] out_year_r;
  logic        out_leap_r;
  logic        out_err_r;

  logic accept, commit;

  cdda_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  assign in_ch.ready = (ctl.op == cdda_pkg::OP_ACCEPT);
  assign accept      = in_ch.valid && in_ch.ready;

  // load decode: month clamp, year check, century by reciprocal
  logic [3:0]  ld_month;
  logic        ld_bad;
  logic [26:0] div_prod;
  logic        is_load;

  assign is_load  = (in_ch.kind == cdda_pkg::KIND_LOAD);
  assign ld_month = (in_ch.load_month == 4'd0) ? cdda_pkg::MONTH_JAN :
                    (in_ch.load_month > cdda_pkg::MONTH_DEC) ? cdda_pkg::MONTH_DEC :
                    in_ch.load_month;
  assign ld_bad   = (in_ch.load_year < cdda_pkg::YEAR_MIN) ||
                    (in_ch.load_year > cdda_pkg::YEAR_MAX);
  assign div_prod = 27'(in_ch.load_year) * 27'(cdda_pkg::DIV100_MUL);

  // year mod 100 from the registered century
  logic [13:0] hundreds;
  logic [13:0] lo_diff;
  assign hundreds = {q_r, 6'b0} + {1'b0, q_r, 5'b0} + {4'b0, q_r, 2'b0};
  assign lo_diff  = wy_r - hundreds;

  // one month step of the walk
  logic       w_leap;
  logic [4:0] len_cur, len_prev;
  logic [3:0] prev_m;
  logic       back, fwd, low_edge, high_edge;

  assign w_leap    = cdda_pkg::is_leap(w_lo_r, w_hi2_r);
  assign prev_m    = (wm_r == cdda_pkg::MONTH_JAN) ? cdda_pkg::MONTH_DEC : wm_r - 4'd1;
  assign len_cur   = cdda_pkg::month_len(wm_r, w_leap);
  assign len_prev  = cdda_pkg::month_len(prev_m, w_leap);
  assign back      = (wd_r <= $signed({WD_W{1'b0}}));
  assign fwd       = (wd_r > $signed({{(WD_W-5){1'b0}}, len_cur}));
  assign low_edge  = (wy_r == cdda_pkg::YEAR_MIN) && (wm_r == cdda_pkg::MONTH_JAN);
  assign high_edge = (wy_r == cdda_pkg::YEAR_MAX) && (wm_r == cdda_pkg::MONTH_DEC);

  assign flags.accept   = accept;
  assign flags.skip     = keep_r;
  assign flags.walking  = (back && !low_edge) || (fwd && !high_edge);
  assign flags.out_busy = out_valid_r && !out_ch.ready;

  assign commit = (ctl.op == cdda_pkg::OP_COMMIT) && !flags.out_busy;

  // working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r  <= 1'b0;
      keep_r <= 1'b0;
      load_r <= 1'b0;
    end else begin
      unique case (ctl.op)
        cdda_pkg::OP_ACCEPT: begin
          if (accept) begin
            load_r <= is_load;
            err_r  <= is_load && ld_bad;
            keep_r <= (is_load && ld_bad) || (in_ch.kind > cdda_pkg::KIND_LOAD);
          end
        end
        cdda_pkg::OP_WALK: begin
          if ((back && low_edge) || (fwd && high_edge)) begin
            err_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      cdda_pkg::OP_ACCEPT: begin
        if (accept) begin
          q_r <= div_prod[26:cdda_pkg::DIV100_SHIFT];
          priority if (in_ch.kind == cdda_pkg::KIND_LOAD) begin
            wd_r <= $signed({{(WD_W-5){1'b0}}, in_ch.load_day});
            wm_r <= ld_month;
            wy_r <= in_ch.load_year;
          end else if (in_ch.kind == cdda_pkg::KIND_SUB) begin
            wd_r <= $signed({{(WD_W-5){1'b0}}, cur_day_r})
                  - $signed({2'b00, in_ch.day_count});
            wm_r <= cur_month_r;
            wy_r <= cur_year_r;
          end else begin
            wd_r <= $signed({{(WD_W-5){1'b0}}, cur_day_r})
                  + $signed({2'b00, in_ch.day_count});
            wm_r <= cur_month_r;
            wy_r <= cur_year_r;
          end
          w_lo_r  <= cur_lo_r;
          w_hi2_r <= cur_hi2_r;
        end
      end
      cdda_pkg::OP_SPLIT: begin
        if (load_r) begin
          w_lo_r  <= lo_diff[6:0];
          w_hi2_r <= q_r[1:0];
        end
      end
      cdda_pkg::OP_WALK: begin
        if (back && !low_edge) begin
          // step back into the previous month
          wd_r <= wd_r + $signed({{(WD_W-5){1'b0}}, len_prev});
          wm_r <= prev_m;
          if (wm_r == cdda_pkg::MONTH_JAN) begin
            wy_r    <= wy_r - 14'd1;
            w_lo_r  <= (w_lo_r == 7'd0) ? cdda_pkg::LO_MAX : w_lo_r - 7'd1;
            w_hi2_r <= w_hi2_r - {1'b0, (w_lo_r == 7'd0)};
          end
        end else if (fwd && !high_edge) begin
          // step over the current month
          wd_r <= wd_r - $signed({{(WD_W-5){1'b0}}, len_cur});
          wm_r <= (wm_r == cdda_pkg::MONTH_DEC) ? cdda_pkg::MONTH_JAN : wm_r + 4'd1;
          if (wm_r == cdda_pkg::MONTH_DEC) begin
            wy_r    <= wy_r + 14'd1;
            w_lo_r  <= (w_lo_r == cdda_pkg::LO_MAX) ? 7'd0 : w_lo_r + 7'd1;
            w_hi2_r <= w_hi2_r + {1'b0, (w_lo_r == cdda_pkg::LO_MAX)};
          end
        end
      end
      default: ;
    endcase
  end

  // committed date
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_day_r   <= cdda_pkg::DAY_FIRST;
      cur_month_r <= cdda_pkg::MONTH_JAN;
      cur_year_r  <= cdda_pkg::YEAR_RESET;
      cur_lo_r    <= cdda_pkg::LO_RESET;
      cur_hi2_r   <= cdda_pkg::HI2_RESET;
    end else if (commit && !err_r && !keep_r) begin
      cur_day_r   <= wd_r[4:0];
      cur_month_r <= wm_r;
      cur_year_r  <= wy_r;
      cur_lo_r    <= w_lo_r;
      cur_hi2_r   <= w_hi2_r;
    end
  end

  // result register
  logic change;
  assign change = !err_r && !keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_day_r   <= change ? wd_r[4:0] : cur_day_r;
      out_month_r <= change ? wm_r : cur_month_r;
      out_year_r  <= change ? wy_r : cur_year_r;
      out_leap_r  <= change ? w_leap : cdda_pkg::is_leap(cur_lo_r, cur_hi2_r);
      out_err_r   <= err_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.day          = out_day_r;
  assign out_ch.month        = out_month_r;
  assign out_ch.year         = out_year_r;
  assign out_ch.leap_year    = out_leap_r;
  assign out_ch.out_of_range = out_err_r;

  // stored date is always a real date
  a_cur_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_month_r >= cdda_pkg::MONTH_JAN) && (cur_month_r <= cdda_pkg::MONTH_DEC) &&
    (cur_day_r != 5'd0) && (cur_lo_r <= cdda_pkg::LO_MAX))
    else $error("stored date out of range");

  // a result appears only after the commit step
  a_out_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.op == cdda_pkg::OP_COMMIT))
    else $error("result without commit");

  // a refused word leaves the stored date alone
  a_refused_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_err_r |-> $stable(cur_year_r) && $stable(cur_day_r) &&
    $stable(cur_month_r))
    else $error("refused word changed the date");

  // no new word is taken during the month walk
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == cdda_pkg::OP_WALK) |-> !accept)
    else $error("word accepted during walk");

endmodule

### rtl/cdda_seq.sv
module cdda_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  cdda_pkg::flags_t flags,
  output cdda_pkg::ctl_t   ctl
);

  // step codes
  localparam cdda_pkg::pc_t PC_IDLE   = 2'd0;
  localparam cdda_pkg::pc_t PC_SPLIT  = 2'd1;
  localparam cdda_pkg::pc_t PC_WALK   = 2'd2;
  localparam cdda_pkg::pc_t PC_COMMIT = 2'd3;

  // control program: on a true condition jump to target, else fall through
  localparam cdda_pkg::ctl_t UCODE [4] = '{
    '{op: cdda_pkg::OP_ACCEPT, jc: cdda_pkg::JC_NO_ACCEPT, target: PC_IDLE},
    '{op: cdda_pkg::OP_SPLIT,  jc: cdda_pkg::JC_SKIP,      target: PC_COMMIT},
    '{op: cdda_pkg::OP_WALK,   jc: cdda_pkg::JC_WALKING,   target: PC_WALK},
    '{op: cdda_pkg::OP_COMMIT, jc: cdda_pkg::JC_OUT_BUSY,  target: PC_COMMIT}
  };

  cdda_pkg::pc_t pc_r, pc_nxt;
  logic          taken;

  assign ctl = UCODE[pc_r];

  // condition select
  always_comb begin
    unique case (ctl.jc)
      cdda_pkg::JC_NO_ACCEPT: taken = !flags.accept;
      cdda_pkg::JC_SKIP:      taken = flags.skip;
      cdda_pkg::JC_WALKING:   taken = flags.walking;
      cdda_pkg::JC_OUT_BUSY:  taken = flags.out_busy;
      default:                taken = 1'b0;
    endcase
  end

  // next step, falling through wraps the commit step back to idle
  assign pc_nxt = taken ? ctl.target : pc_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
